[src/pdve_pkg.sv]
// Shared types and constants for the posting list delta varbyte encoder.
// Used by pdve_ctrl, pdve_datapath and the top level; depends on nothing.
`default_nettype none
package pdve_pkg;

   localparam logic [6:0] VB_MASK7 = 7'h7F;
   localparam logic [7:0] VB_CONT  = 8'h80;
   localparam int unsigned VB_SHIFT = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VALUE,
      ST_COUNT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic accept;      // capture the offered item
      logic emit_value;  // emit one value byte
      logic emit_count;  // emit one count byte
      logic emit_empty;  // emit the header of an empty list
   } cmd_type;

   typedef struct packed {
      logic slot_free;   // output register can take a result
      logic more;        // more 7-bit groups follow the current byte
      logic kind;        // document lists carry a count code
   } status_type;

endpackage
`default_nettype wire

[src/pdve_ctrl.sv]
// Controller state machine: sequences one item from accept through its last result.
// Depends on pdve_pkg for the state, command and status types.
`default_nettype none
module pdve_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_empty_list,
   output logic                 req_ready,
   input  pdve_pkg::status_type status,
   output pdve_pkg::cmd_type    cmd
);

   pdve_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdve_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_empty_list ? pdve_pkg::ST_EMPTY : pdve_pkg::ST_VALUE;
            end
         end
         pdve_pkg::ST_VALUE: begin
            if (status.slot_free && !status.more) begin
               state_in = status.kind ? pdve_pkg::ST_COUNT : pdve_pkg::ST_IDLE;
            end
         end
         pdve_pkg::ST_COUNT: begin
            if (status.slot_free && !status.more) begin
               state_in = pdve_pkg::ST_IDLE;
            end
         end
         pdve_pkg::ST_EMPTY: begin
            if (status.slot_free) begin
               state_in = pdve_pkg::ST_IDLE;
            end
         end
         default: state_in = pdve_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         pdve_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid && !req_empty_list;
         end
         pdve_pkg::ST_VALUE: cmd.emit_value = status.slot_free;
         pdve_pkg::ST_COUNT: cmd.emit_count = status.slot_free;
         pdve_pkg::ST_EMPTY: cmd.emit_empty = status.slot_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdve_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[src/pdve_datapath.sv]
// Datapath: delta, 7-bit group shifter, list and offset counters, output register.
// Depends on pdve_pkg; driven by commands from pdve_ctrl.
`default_nettype none
module pdve_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write_enable,
   input  wire                  csr_write_data,
   input  wire  [31:0]          req_element_value,
   input  wire  [31:0]          req_element_count,
   input  wire                  req_first_in_list,
   input  wire                  req_last_in_list,
   input  pdve_pkg::cmd_type    cmd,
   output pdve_pkg::status_type status,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [7:0]           rsp_code_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last_of_item,
   output logic                 rsp_header_valid,
   output logic [63:0]          rsp_list_offset,
   output logic [31:0]          rsp_list_length
);

   logic        kind_ff, kind_in;
   logic [31:0] prev_ff, prev_in;
   logic [63:0] offset_ff, offset_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [63:0] start_ff, start_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] count_ff, count_in;
   logic        last_ff, last_in;

   logic        valid_ff, valid_in;
   logic [7:0]  code_ff, code_in;
   logic        bvalid_ff, bvalid_in;
   logic        lastitem_ff, lastitem_in;
   logic        hvalid_ff, hvalid_in;
   logic [63:0] loff_ff, loff_in;
   logic [31:0] llen_ff, llen_in;

   logic        more;
   logic        emit;
   logic        final_byte;
   logic [63:0] offset_inc;
   logic [31:0] bytes_inc;

   assign more       = |shift_ff[31:pdve_pkg::VB_SHIFT];
   assign emit       = cmd.emit_value | cmd.emit_count;
   assign final_byte = !more && (cmd.emit_count || !kind_ff);
   assign offset_inc = offset_ff + 64'd1;
   assign bytes_inc  = bytes_ff + 32'd1;

   assign status.slot_free = !valid_ff || rsp_ready;
   assign status.more      = more;
   assign status.kind      = kind_ff;

   always_comb begin
      kind_in     = csr_write_enable ? csr_write_data : kind_ff;
      prev_in     = prev_ff;
      offset_in   = offset_ff;
      bytes_in    = bytes_ff;
      start_in    = start_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      valid_in    = valid_ff && !rsp_ready;
      code_in     = code_ff;
      bvalid_in   = bvalid_ff;
      lastitem_in = lastitem_ff;
      hvalid_in   = hvalid_ff;
      loff_in     = loff_ff;
      llen_in     = llen_ff;

      if (cmd.accept) begin
         count_in = req_element_count;
         last_in  = req_last_in_list;
         if (req_first_in_list) begin
            shift_in = req_element_value;
            start_in = offset_ff;
            bytes_in = '0;
         end else begin
            shift_in = req_element_value - prev_ff;
         end
         prev_in = req_element_value;
      end

      if (emit) begin
         valid_in    = 1'b1;
         code_in     = {more, shift_ff[6:0] & pdve_pkg::VB_MASK7};
         bvalid_in   = 1'b1;
         lastitem_in = final_byte;
         hvalid_in   = final_byte && last_ff;
         loff_in     = (final_byte && last_ff) ? start_ff : '0;
         llen_in     = (final_byte && last_ff) ? bytes_inc : '0;
         offset_in   = offset_inc;
         bytes_in    = bytes_inc;
         shift_in    = shift_ff >> pdve_pkg::VB_SHIFT;
         if (cmd.emit_value && !more && kind_ff) begin
            shift_in = count_ff;
         end
         if (final_byte && last_ff) begin
            start_in = offset_inc;
            bytes_in = '0;
         end
      end

      if (cmd.emit_empty) begin
         valid_in    = 1'b1;
         code_in     = '0;
         bvalid_in   = 1'b0;
         lastitem_in = 1'b1;
         hvalid_in   = 1'b1;
         loff_in     = offset_ff;
         llen_in     = '0;
         start_in    = offset_ff;
         bytes_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= 1'b0;
         prev_ff   <= '0;
         offset_ff <= '0;
         bytes_ff  <= '0;
         start_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         kind_ff   <= kind_in;
         prev_ff   <= prev_in;
         offset_ff <= offset_in;
         bytes_ff  <= bytes_in;
         start_ff  <= start_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      code_ff     <= code_in;
      bvalid_ff   <= bvalid_in;
      lastitem_ff <= lastitem_in;
      hvalid_ff   <= hvalid_in;
      loff_ff     <= loff_in;
      llen_ff     <= llen_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_byte    = code_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_last_of_item = lastitem_ff;
   assign rsp_header_valid = hvalid_ff;
   assign rsp_list_offset  = loff_ff;
   assign rsp_list_length  = llen_ff;

endmodule
`default_nettype wire

[src/posting_delta_varbyte_encoder_unit.sv]
// Top level of the posting list delta varbyte encoder.
// Joins pdve_ctrl and pdve_datapath; depends on pdve_pkg.
//
// Each accepted item is captured, then its results follow one after another:
// 1 to 5 value bytes, plus 1 to 5 count bytes when record_kind is 1, or
// a single header result for an empty list. The value and count bytes come from
// the byte-at-a-time shifter that serializes the 7-bit groups. Results
// leave through an output register; while a result waits for rsp_ready no further
// byte is produced, but the final result of an item may wait while the next item
// is captured. The header of a closed list (start offset and byte length) rides on
// the final result of its closing item.
`default_nettype none
module posting_delta_varbyte_encoder_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write_enable,
   input  wire         csr_write_data,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_element_value,
   input  wire  [31:0] req_element_count,
   input  wire         req_first_in_list,
   input  wire         req_last_in_list,
   input  wire         req_empty_list,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_item,
   output logic        rsp_header_valid,
   output logic [63:0] rsp_list_offset,
   output logic [31:0] rsp_list_length
);

   pdve_pkg::cmd_type    cmd;
   pdve_pkg::status_type status;

   pdve_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_empty_list (req_empty_list),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   pdve_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_element_value (req_element_value),
      .req_element_count (req_element_count),
      .req_first_in_list (req_first_in_list),
      .req_last_in_list  (req_last_in_list),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_header_valid  (rsp_header_valid),
      .rsp_list_offset   (rsp_list_offset),
      .rsp_list_length   (rsp_list_length)
   );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for posting_delta_varbyte_encoder_unit: a directed table, then random
// posting lists in both record kinds, checked against an in-bench delta varbyte encoder.
// Depends on pdve_pkg and the encoder RTL only.
`timescale 1ns / 1ps
module tb_top;

   localparam int RANDOM_ITEMS     = 456;
   localparam int PHASE_COUNT      = 6;
   localparam int MAX_WAIT         = 12;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int REPORT_LIMIT     = 10;
   localparam logic KIND_POS = 1'b0;
   localparam logic KIND_DOC = 1'b1;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] count;
      logic        first;
      logic        last;
      logic        empty;
   } posting_item_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        byte_valid;
      logic        last_of_item;
      logic        header_valid;
      logic [63:0] list_offset;
      logic [31:0] list_length;
   } code_result_type;

   typedef code_result_type code_list_type[$];

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic [31:0] count;
      logic        first;
      logic        last;
      logic        empty;
      logic        typed;
      logic [3:0]  n_bytes;
      logic [79:0] bytes;
      logic [63:0] offset;
      logic [31:0] length;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 23;
   // kind, value, count, first, last, empty | typed, bytes, codes low first, offset, length
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{KIND_POS, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 1'b1,
        1'b1, 4'd1, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h00000000, 32'hffffffff, 1'b1, 1'b0, 1'b0,
        1'b1, 4'd1, 80'h00, 64'd0, 32'd0},
      '{KIND_POS, 32'hffffffff, 32'h00000000, 1'b0, 1'b1, 1'b0,
        1'b1, 4'd5, 80'h0fffffffff, 64'd0, 32'd6},
      '{KIND_POS, 32'h00000080, 32'h00000000, 1'b1, 1'b1, 1'b0,
        1'b1, 4'd2, 80'h0180, 64'd6, 32'd2},
      '{KIND_POS, 32'h0000007f, 32'h00000000, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h00003fff, 32'h00000000, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h00007fff, 32'h00000000, 1'b0, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h12345678, 32'h9abcdef0, 1'b0, 1'b0, 1'b1,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h001fffff, 32'h00000000, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h0fffffff, 32'h00000000, 1'b0, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h0000007f, 32'h0000007f, 1'b1, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00000080, 32'h00000080, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00004000, 32'h00003fff, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00200000, 32'h00004000, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h10000000, 32'h001fffff, 1'b0, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'hffffffff, 32'h00200000, 1'b1, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00000000, 32'h00000000, 1'b1, 1'b1, 1'b1,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'h00000005, 32'h10000000, 1'b0, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_DOC, 32'haaaaaaaa, 32'h55555555, 1'b1, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'h55555555, 32'haaaaaaaa, 1'b1, 1'b0, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0},
      '{KIND_POS, 32'haaaaaaaa, 32'h55555555, 1'b0, 1'b1, 1'b0,
        1'b0, 4'd0, 80'h0, 64'd0, 32'd0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_element_value = '0;
   logic [31:0] req_element_count = '0;
   logic        req_first_in_list = 1'b0;
   logic        req_last_in_list = 1'b0;
   logic        req_empty_list = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_code_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_item;
   logic        rsp_header_valid;
   logic [63:0] rsp_list_offset;
   logic [31:0] rsp_list_length;

   // encoder model state
   logic        doc_mode = KIND_POS;
   logic [31:0] last_value = '0;
   logic [63:0] byte_offset = '0;
   logic [31:0] open_bytes = '0;
   logic [63:0] open_start = '0;

   code_result_type pending_codes[$];
   code_list_type   no_override;

   int items_sent = 0;
   int empty_lists_sent = 0;
   int codes_seen = 0;
   int failures = 0;
   int idle_cycles = 0;
   int sender_gap = 0;
   int sender_calm = 0;
   int receiver_calm = 0;

   posting_delta_varbyte_encoder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .req_element_count (req_element_count),
      .req_first_in_list (req_first_in_list),
      .req_last_in_list  (req_last_in_list),
      .req_empty_list    (req_empty_list),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_header_valid  (rsp_header_valid),
      .rsp_list_offset   (rsp_list_offset),
      .rsp_list_length   (rsp_list_length)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic code_list_type encode_posting(input posting_item_type it);
      code_list_type   codes;
      code_result_type r;
      logic [31:0]     number;
      int              parts;
      if (it.empty) begin
         r = '0;
         r.last_of_item = 1'b1;
         r.header_valid = 1'b1;
         r.list_offset = byte_offset;
         codes = {codes, r};
         open_start = byte_offset;
         open_bytes = '0;
         return codes;
      end
      if (it.first) begin
         open_start = byte_offset;
         open_bytes = '0;
      end
      parts = doc_mode ? 2 : 1;
      for (int p = 0; p < parts; p++) begin
         number = (p == 0) ? (it.first ? it.value : it.value - last_value) : it.count;
         do begin
            r = '0;
            r.code_byte = {1'b0, number[6:0] & pdve_pkg::VB_MASK7};
            number = number >> pdve_pkg::VB_SHIFT;
            if (number != 0) r.code_byte = r.code_byte | pdve_pkg::VB_CONT;
            r.byte_valid = 1'b1;
            codes = {codes, r};
         end while (number != 0);
      end
      last_value = it.value;
      open_bytes = open_bytes + 32'(codes.size());
      byte_offset = byte_offset + 64'(codes.size());
      r = codes.pop_back();
      r.last_of_item = 1'b1;
      if (it.last) begin
         r.header_valid = 1'b1;
         r.list_offset = open_start;
         r.list_length = open_bytes;
         open_start = byte_offset;
         open_bytes = '0;
      end
      codes = {codes, r};
      return codes;
   endfunction

   function automatic code_list_type typed_codes(input directed_row_type row);
      code_list_type   codes;
      code_result_type r;
      if (row.empty) begin
         r = '0;
         r.last_of_item = 1'b1;
         r.header_valid = 1'b1;
         r.list_offset = row.offset;
         r.list_length = row.length;
         codes = {codes, r};
      end else begin
         for (int i = 0; i < int'(row.n_bytes); i++) begin
            r = '0;
            r.code_byte = row.bytes[8*i +: 8];
            r.byte_valid = 1'b1;
            if (i == int'(row.n_bytes) - 1) begin
               r.last_of_item = 1'b1;
               if (row.last) begin
                  r.header_valid = 1'b1;
                  r.list_offset = row.offset;
                  r.list_length = row.length;
               end
            end
            codes = {codes, r};
         end
      end
      return codes;
   endfunction

   function automatic string describe(input code_result_type r);
      return $sformatf("byte=%h bv=%b last=%b hdr=%b off=%h len=%h", r.code_byte,
                       r.byte_valid, r.last_of_item, r.header_valid, r.list_offset,
                       r.list_length);
   endfunction

   function automatic logic [31:0] draw_magnitude();
      int unsigned w;
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 14);
      if (w >= 32) return $urandom;
      return $urandom & ((32'd1 << w) - 32'd1);
   endfunction

   task automatic draw_wait(inout int calm, output int cycles);
      if (calm > 0) begin
         calm--;
         cycles = 0;
      end else if ($urandom_range(0, 29) == 0) begin
         calm = $urandom_range(20, 60);
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, MAX_WAIT);
      end
   endtask

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic offer_item(input posting_item_type it, input code_list_type typed);
      code_list_type predicted;
      repeat (sender_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_element_value <= it.value;
      req_element_count <= it.count;
      req_first_in_list <= it.first;
      req_last_in_list <= it.last;
      req_empty_list <= it.empty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = encode_posting(it);
      if (typed.size() != 0) predicted = typed;
      pending_codes = {pending_codes, predicted};
      items_sent++;
      if (it.empty) empty_lists_sent++;
      draw_wait(sender_calm, sender_gap);
      if (sender_gap != 0) req_valid <= 1'b0;
   endtask

   task automatic drain_block();
      if (sender_gap == 0) req_valid <= 1'b0;
      do @(negedge clock); while (pending_codes.size() != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_record_kind(input logic kind);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= kind;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      doc_mode = kind;
   endtask

   task automatic run_random_phase(input int quota, input logic pause_midway);
      int               sent;
      int               pick;
      int               span;
      logic             paused;
      logic [31:0]      value;
      posting_item_type it;
      sent = 0;
      paused = 1'b0;
      while (sent < quota) begin
         if (pause_midway && !paused && sent >= quota / 2) begin
            drain_block();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75 || pick >= 90) begin
            // well-formed list, or an opened list that is never closed
            span = $urandom_range(1, 8);
            if (span > quota - sent) span = quota - sent;
            value = ($urandom_range(0, 1) == 0) ? draw_magnitude() : $urandom;
            for (int k = 0; k < span; k++) begin
               it.value = value;
               it.count = draw_magnitude();
               it.first = (k == 0);
               it.last = (pick < 75) && (k == span - 1);
               it.empty = 1'b0;
               offer_item(it, no_override);
               value = value + draw_magnitude();
               sent++;
            end
         end else begin
            it.value = $urandom;
            it.count = $urandom;
            it.first = 1'($urandom_range(0, 1));
            it.last = 1'($urandom_range(0, 1));
            it.empty = (pick < 82);
            offer_item(it, no_override);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_codes.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int              stall;
      code_result_type got;
      code_result_type want;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (codes_seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
         else draw_wait(receiver_calm, stall);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = '{rsp_code_byte, rsp_byte_valid, rsp_last_of_item, rsp_header_valid,
                 rsp_list_offset, rsp_list_length};
         codes_seen++;
         if (pending_codes.size() == 0) begin
            note_failure($sformatf("unexpected result %s", describe(got)));
         end else begin
            want = pending_codes.pop_front();
            if (got !== want) begin
               note_failure($sformatf("result %0d expected %s got %s", codes_seen,
                                      describe(want), describe(got)));
            end
         end
      end
   end

   initial begin
      posting_item_type it;
      directed_row_type row;
      logic             kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_record_kind(DIRECTED_ROWS[0].kind);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind != doc_mode) set_record_kind(row.kind);
         it.value = row.value;
         it.count = row.count;
         it.first = row.first;
         it.last = row.last;
         it.empty = row.empty;
         if (row.typed) offer_item(it, typed_codes(row));
         else offer_item(it, no_override);
      end
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == PHASE_COUNT - 1) kind = 1'($urandom_range(0, 1));
         else kind = (p % 2 == 0) ? KIND_DOC : KIND_POS;
         set_record_kind(kind);
         run_random_phase(RANDOM_ITEMS / PHASE_COUNT, p == 2);
      end
      drain_block();
      $display("Covered %0d items (%0d directed, %0d empty lists) and %0d results", items_sent,
               DIRECTED_COUNT, empty_lists_sent, codes_seen);
      $display("over both record kinds, a long output hold and a full drain; %0d mismatches",
               failures);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
